[src/slsc_pkg.sv]
// Shared types, constants and codes for the shift-latch serial capture block.
package slsc_pkg;

	// Default sizing of the batch buffer and its chunks.
	localparam int BATCH_BYTES_DEF = 256;
	localparam int N_CHUNKS_DEF    = 4;

	// Longest run of bytes that one send item produces.
	localparam int MAX_SEND = 64;

	// Codeword length register.
	localparam int          CW_W     = 5;
	localparam logic [4:0]  CW_RESET = 5'd8;
	localparam logic [4:0]  CW_BYTE  = 5'd8;

	// Input item operations.
	typedef enum logic [1:0] {
		OP_CLK   = 2'd0,
		OP_LATCH = 2'd1,
		OP_SEND  = 2'd2,
		OP_REARM = 2'd3
	} op_t;

	// Result kinds.
	localparam logic KIND_FULL = 1'b0;
	localparam logic KIND_BYTE = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_HI,
		ST_NOTE,
		ST_RD,
		ST_LD
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic shift;
		logic clear_acc;
		logic wr_lo;
		logic wr_hi;
		logic capture_off;
		logic rearm;
		logic send_start;
		logic load_note;
		logic load_byte;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic capture_en;
		logic two_byte;
		logic fits;
		logic last_byte;
		logic out_free;
		logic chunk_ok;
		logic send_last;
	} status_t;

endpackage

[src/shift_latch_serial_capture.sv]
// Top level of the shift-latch serial capture block.
//
// Input items arrive on s_tvalid/s_tready with the operation in s_tuser and
// the data bit and chunk select in s_tdata. Results leave on
// m_tvalid/m_tready/m_tdata/m_tuser/m_tlast through a single result register.
// A serial clock edge, a rearm, an ignored item and a one-byte latch are each
// handled in the idle state. A two-byte latch writes the low byte and then the
// high byte in ST_WR_HI, the buffer having a single write port. A latch that
// fills the batch also puts out a full notice. A send item walks its chunk
// byte by byte through ST_RD and ST_LD, set by the registered read of the
// batch buffer. While a chunk or a pending notice is in progress no new item
// is taken; a waiting result does not block idle input items. When the
// receiver stalls the result register holds its value. Reset clears the
// accumulator and fill index, resumes capture and sets the codeword length to
// 8; the buffer is not cleared. The codeword length is written through cfg_we and
// cfg_wdata; the user must write it only while idle, which the block does not enforce.
module shift_latch_serial_capture import slsc_pkg::*; #(
	parameter int BATCH_BYTES = BATCH_BYTES_DEF,
	parameter int N_CHUNKS    = N_CHUNKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,   // data_bit[0], chunk_select[2:1], zero pad
	input  logic [1:0]      s_tuser,   // operation[1:0]
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [15:0]     m_tdata,   // chunk_number[1:0], byte_offset[7:2], data_byte[15:8]
	output logic [1:0]      m_tuser,   // kind[0], format[1]
	output logic            m_tlast,
	input  logic            cfg_we,
	input  logic [CW_W-1:0] cfg_wdata
);

	cmd_t    cmd;
	status_t status;

	// Sequencing of items.
	slsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.operation(op_t'(s_tuser)),
		.status   (status),
		.cmd      (cmd)
	);

	// Storage and result path.
	slsc_datapath #(
		.BATCH_BYTES(BATCH_BYTES),
		.N_CHUNKS   (N_CHUNKS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.data_bit    (s_tdata[0]),
		.chunk_select(s_tdata[2:1]),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

[src/slsc_ram.sv]
// Generic single-port-write, registered-read RAM.
module slsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/slsc_datapath.sv]
// Datapath: accumulator, fill index, batch buffer, chunk readout and result register.
module slsc_datapath import slsc_pkg::*; #(
	parameter int BATCH_BYTES = BATCH_BYTES_DEF,
	parameter int N_CHUNKS    = N_CHUNKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cmd_t            cmd,
	output status_t         status,
	input  logic            data_bit,
	input  logic [1:0]      chunk_select,
	input  logic            cfg_we,
	input  logic [CW_W-1:0] cfg_wdata,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [15:0]     m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);

	localparam int AW          = $clog2(BATCH_BYTES);
	localparam int FW          = $clog2(BATCH_BYTES + 1);
	localparam int CHUNK_BYTES = BATCH_BYTES / N_CHUNKS;
	localparam int SEND_LEN    = (CHUNK_BYTES > MAX_SEND) ? MAX_SEND : CHUNK_BYTES;

	logic [CW_W-1:0] cw_q;
	logic [15:0]     acc_q;
	logic [FW-1:0]   fill_q;
	logic            capture_q;
	logic [1:0]      sel_q;
	logic [5:0]      off_q;

	logic            out_valid_q;
	logic            out_kind_q;
	logic            out_format_q;
	logic [1:0]      out_chunk_q;
	logic [5:0]      out_off_q;
	logic [7:0]      out_byte_q;
	logic            out_last_q;

	logic            two_byte;
	logic [FW:0]     need_end;
	logic            wen;
	logic [7:0]      wdata;
	logic [AW-1:0]   raddr;
	logic [7:0]      rdata;
	logic            out_free;

	// Decoded status for the controller.
	assign two_byte = (cw_q > CW_BYTE);
	assign need_end = {1'b0, fill_q} + (two_byte ? (FW+1)'(2) : (FW+1)'(1));
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		status.capture_en = capture_q;
		status.two_byte   = two_byte;
		status.fits       = (need_end <= (FW+1)'(BATCH_BYTES));
		status.last_byte  = (fill_q == FW'(BATCH_BYTES - 1));
		status.out_free   = out_free;
		status.chunk_ok   = !capture_q && (SEND_LEN != 0)
			&& ({1'b0, chunk_select} < 3'(N_CHUNKS > 4 ? 4 : N_CHUNKS));
		status.send_last  = (off_q == 6'(SEND_LEN - 1));
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= CW_RESET;
		end else if (cfg_we) begin
			cw_q <= cfg_wdata;
		end
	end

	// Capture state: accumulator, fill index and capture flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			fill_q    <= '0;
			capture_q <= 1'b1;
		end else begin
			if (cmd.rearm || cmd.clear_acc) begin
				acc_q <= '0;
			end else if (cmd.shift) begin
				acc_q <= {acc_q[14:0], data_bit};
			end
			if (cmd.rearm) begin
				fill_q <= '0;
			end else if (wen) begin
				fill_q <= fill_q + FW'(1);
			end
			if (cmd.rearm) begin
				capture_q <= 1'b1;
			end else if (cmd.capture_off) begin
				capture_q <= 1'b0;
			end
		end
	end

	// Batch buffer write: low byte first, high byte in the following cycle.
	assign wen   = cmd.wr_lo || cmd.wr_hi;
	assign wdata = cmd.wr_hi ? acc_q[15:8] : acc_q[7:0];

	// Readout position within the batch.
	assign raddr = AW'(sel_q) * AW'(CHUNK_BYTES) + AW'(off_q);

	slsc_ram #(
		.WIDTH(8),
		.DEPTH(BATCH_BYTES)
	) u_ram (
		.clk  (clk),
		.wen  (wen),
		.waddr(AW'(fill_q)),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Chunk readout counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
			off_q <= '0;
		end else if (cmd.send_start) begin
			sel_q <= chunk_select;
			off_q <= '0;
		end else if (cmd.load_byte) begin
			off_q <= off_q + 6'd1;
		end
	end

	// Result register; it holds while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_note || cmd.load_byte) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_note) begin
			out_kind_q   <= KIND_FULL;
			out_format_q <= two_byte;
			out_chunk_q  <= '0;
			out_off_q    <= '0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b1;
		end else if (cmd.load_byte) begin
			out_kind_q   <= KIND_BYTE;
			out_format_q <= two_byte;
			out_chunk_q  <= sel_q;
			out_off_q    <= off_q;
			out_byte_q   <= rdata;
			out_last_q   <= status.send_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_byte_q, out_off_q, out_chunk_q};
	assign m_tuser  = {out_format_q, out_kind_q};
	assign m_tlast  = out_last_q;

	// The fill index never passes the end of the batch.
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= FW'(BATCH_BYTES))
		else $error("fill index beyond batch end");

	// Nothing is written into the batch once capture has stopped.
	assert property (@(posedge clk) disable iff (!arst_n) wen |-> capture_q)
		else $error("batch write while capture stopped");

	// Capture only stops on a full batch.
	assert property (@(posedge clk) disable iff (!arst_n)
		!capture_q |-> (fill_q == FW'(BATCH_BYTES)))
		else $error("capture stopped on a batch that is not full");

	// A result is never loaded over one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_note || cmd.load_byte) |-> out_free)
		else $error("result register overwritten");

endmodule

[src/slsc_ctrl.sv]
// Controller state machine for the shift-latch serial capture block.
module slsc_ctrl import slsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  op_t     operation,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (operation)
						OP_CLK: begin
							cmd.shift = status.capture_en;
						end
						OP_LATCH: begin
							if (status.capture_en) begin
								if (status.fits) begin
									cmd.wr_lo = 1'b1;
									if (status.two_byte) begin
										state_d = ST_WR_HI;
									end else begin
										cmd.clear_acc = 1'b1;
										if (status.last_byte) begin
											cmd.capture_off = 1'b1;
											if (status.out_free) begin
												cmd.load_note = 1'b1;
											end else begin
												state_d = ST_NOTE;
											end
										end
									end
								end else begin
									cmd.clear_acc = 1'b1;
								end
							end
						end
						OP_SEND: begin
							if (status.chunk_ok) begin
								cmd.send_start = 1'b1;
								state_d        = ST_RD;
							end
						end
						OP_REARM: begin
							cmd.rearm = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WR_HI: begin
				cmd.wr_hi     = 1'b1;
				cmd.clear_acc = 1'b1;
				state_d       = ST_IDLE;
				if (status.last_byte) begin
					cmd.capture_off = 1'b1;
					if (status.out_free) begin
						cmd.load_note = 1'b1;
					end else begin
						state_d = ST_NOTE;
					end
				end
			end
			ST_NOTE: begin
				if (status.out_free) begin
					cmd.load_note = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_RD: begin
				// Buffer read data becomes valid in the next cycle.
				state_d = ST_LD;
			end
			ST_LD: begin
				if (status.out_free) begin
					cmd.load_byte = 1'b1;
					state_d       = status.send_last ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A two-byte write always follows a latch in the idle state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR_HI) |-> ($past(state_q) == ST_IDLE))
		else $error("high byte write without a preceding latch");

	// Every buffer read is followed by a load attempt.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |=> (state_q == ST_LD))
		else $error("read cycle not followed by load");

	// Items are only taken in the idle state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.send_start || cmd.rearm || cmd.shift) |-> (state_q == ST_IDLE))
		else $error("item acted on outside idle");

endmodule
